// File: hdl/lgg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgg_pkg: shared types, codes and the B3/S23 cell rule
// Opcode names, the per-row control group and the next-state function used
// by every row cell of the grid.
// ----------------------------------------------------------------------------
package lgg_pkg;

    // Opcode field of an input beat
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    // Payload widths fixed by the stream format
    localparam int OPCODE_W   = 2;
    localparam int ROW_IDX_W  = 5;
    localparam int ROW_DATA_W = 32;
    localparam int S_TDATA_W  = 40;

    // Control handed from the top level to one row cell
    typedef struct packed {
        logic wr_en;   // load the written row into this cell
        logic adv_en;  // step this row one generation
    } cell_ctl_t;

    // B3/S23: above/below are three columns c-1..c+1, mid[1] is the cell itself
    function automatic logic life_next(input logic [2:0] above,
                                       input logic [2:0] mid,
                                       input logic [2:0] below);
        logic [3:0] n;
        n = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
          + 4'(mid[0])   + 4'(mid[2])
          + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);
        return (n == 4'd3) || (mid[1] && (n == 4'd2));
    endfunction

endpackage

// File: hdl/life_generation_grid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_grid: Conway B3/S23 grid with row access over a stream
// A ROWS x COLUMNS grid held as a chain of row cells, written, read or
// advanced by one input beat each.
// ----------------------------------------------------------------------------
// Each input beat carries an opcode (write row, read row, advance one
// generation; code 3 reads) and gives one result beat: the addressed row
// after the operation, or zero when the row index is at or beyond ROWS.
// Cells outside the grid count as dead; nothing wraps. The row cells update
// at the accepting edge (an advance steps all rows at once); the row select
// is then loaded into the output register once that register is free. A new
// beat is taken as soon as that register is loaded, even while its result
// still waits on m_tready. After reset the grid is all dead.
// ----------------------------------------------------------------------------
module life_generation_grid #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] opcode, [6:2] row_index, [38:7] row_cells, [39] zero
    input  logic [lgg_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] row_out
    output logic [lgg_pkg::ROW_DATA_W-1:0] m_tdata
);
    import lgg_pkg::*;

    localparam int RSEL_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = (RSEL_W > ROW_IDX_W) ? RSEL_W : ROW_IDX_W;

    logic [OPCODE_W-1:0]   opcode;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_DATA_W-1:0] row_cells;
    logic                  s_accept;
    logic                  out_load;

    logic [COLUMNS+ROW_DATA_W-1:0] wr_wide;
    logic [COLUMNS-1:0]            wr_row;
    logic [COLUMNS-1:0]            rows_q [ROWS];

    logic                  pend_reg, pend_next;
    logic [ROW_IDX_W-1:0]  idx_reg,  idx_next;
    logic                  mval_reg, mval_next;
    logic [ROW_DATA_W-1:0] mdat_reg, mdat_next;

    logic [IDX_W-1:0]              idx_wide;
    logic                          idx_in_range;
    logic [COLUMNS-1:0]            sel_row;
    logic [COLUMNS+ROW_DATA_W-1:0] rd_wide;

    // Beat fields
    assign opcode    = s_tdata[1:0];
    assign row_index = s_tdata[6:2];
    assign row_cells = s_tdata[38:7];

    assign s_tready = !pend_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_load = pend_reg && (!mval_reg || m_tready);

    // Written row fitted to the grid width
    assign wr_wide = {{COLUMNS{1'b0}}, row_cells};
    assign wr_row  = wr_wide[COLUMNS-1:0];

    // Chain of row cells
    for (genvar r = 0; r < ROWS; r++) begin : g_row
        cell_ctl_t          ctl;
        logic [COLUMNS-1:0] above;
        logic [COLUMNS-1:0] below;

        assign ctl.wr_en  = s_accept && (opcode == OP_WRITE)
                          && (IDX_W'(row_index) == IDX_W'(r));
        assign ctl.adv_en = s_accept && (opcode == OP_ADVANCE);

        if (r == 0) begin : g_top
            assign above = '0;
        end else begin : g_mid_a
            assign above = rows_q[r-1];
        end
        if (r == ROWS - 1) begin : g_bot
            assign below = '0;
        end else begin : g_mid_b
            assign below = rows_q[r+1];
        end

        lgg_row_cell #(
            .COLUMNS   (COLUMNS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .wr_row    (wr_row),
            .above_row (above),
            .below_row (below),
            .row_q     (rows_q[r])
        );
    end

    // Row select for the result
    assign idx_wide     = IDX_W'(idx_reg);
    assign idx_in_range = (32'(idx_reg) < 32'(ROWS));
    assign sel_row      = idx_in_range ? rows_q[idx_wide[RSEL_W-1:0]] : '0;
    assign rd_wide      = {{ROW_DATA_W{1'b0}}, sel_row};

    // Pending item and output register
    always_comb begin
        pend_next = pend_reg;
        idx_next  = idx_reg;
        mval_next = mval_reg;
        mdat_next = mdat_reg;
        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end
        if (out_load) begin
            mval_next = 1'b1;
            mdat_next = rd_wide[ROW_DATA_W-1:0];
            pend_next = 1'b0;
        end
        if (s_accept) begin
            pend_next = 1'b1;
            idx_next  = row_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            mval_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            mval_reg <= mval_next;
        end
        idx_reg  <= idx_next;
        mdat_reg <= mdat_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdat_reg;

    // Checks
    a_accept_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> pend_reg)
        else $error("accepted beat left no pending item");

    a_load_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (!pend_reg && m_tvalid))
        else $error("result load did not clear pending item");

    a_rise_from_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pend_reg))
        else $error("result appeared without a pending item");

    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !idx_in_range) |=> (m_tdata == '0))
        else $error("row beyond the grid returned non-zero data");

endmodule

// File: hdl/lgg_row_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgg_row_cell: one grid row of the cell chain
// Holds one row of cells, shows it to the rows above and below, and on an
// advance computes its next generation from its own and the neighbour rows.
// ----------------------------------------------------------------------------
module lgg_row_cell #(
    parameter int COLUMNS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lgg_pkg::cell_ctl_t   ctl,
    input  logic [COLUMNS-1:0]   wr_row,     // row written by a write beat
    input  logic [COLUMNS-1:0]   above_row,  // neighbour row, zero at the top edge
    input  logic [COLUMNS-1:0]   below_row,  // neighbour row, zero at the bottom edge
    output logic [COLUMNS-1:0]   row_q
);
    import lgg_pkg::*;

    logic [COLUMNS-1:0] row_reg;
    logic [COLUMNS-1:0] row_next;
    logic [COLUMNS-1:0] gen_row;
    logic [COLUMNS+1:0] above_p;
    logic [COLUMNS+1:0] mid_p;
    logic [COLUMNS+1:0] below_p;

    // Dead cells pad both side edges
    assign above_p = {1'b0, above_row, 1'b0};
    assign mid_p   = {1'b0, row_reg,   1'b0};
    assign below_p = {1'b0, below_row, 1'b0};

    // Next generation, every column independent
    always_comb begin
        for (int c = 0; c < COLUMNS; c++) begin
            gen_row[c] = life_next(above_p[c +: 3], mid_p[c +: 3], below_p[c +: 3]);
        end
    end

    always_comb begin
        row_next = row_reg;
        if (ctl.adv_en) begin
            row_next = gen_row;
        end else if (ctl.wr_en) begin
            row_next = wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            row_reg <= row_next;
        end
    end

    assign row_q = row_reg;

endmodule
